// ----- hdl/gwm_pkg.sv -----
// Shared constants and types for the glob wildcard matcher.
`default_nettype none

package gwm_pkg;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES_2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES_3 = 3'd4;

  localparam int LEN_W       = 6;
  localparam int DATA_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int PAT_REGS    = 4;
  // pattern bytes held in the registers; positions above read as zero
  localparam int REG_BYTES   = 32;

  localparam logic [BYTE_W-1:0] CHAR_ANY = 8'h3F;  // '?'
  localparam logic [BYTE_W-1:0] CHAR_RUN = 8'h2A;  // '*'

  // broadcast to every cell
  typedef struct packed {
    logic step;     // input beat accepted this cycle
    logic restart;  // beat ends the string
    logic empty;    // beat carries no byte
  } cell_ctl_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic fwd;      // live star position: next position live as well
    logic adv;      // byte consumed: next position live after this beat
  } cell_link_t;

endpackage

`default_nettype wire

// ----- hdl/gwm_cell.sv -----
// One pattern position: live bit, star closure and byte advance.
`default_nettype none

module gwm_cell #(
  parameter logic START = 1'b0
) (
  input  wire                             clk,
  input  wire                             rst,
  input  gwm_pkg::cell_ctl_t              ctl,
  input  wire  [gwm_pkg::BYTE_W-1:0]      value_byte,
  input  wire  [gwm_pkg::BYTE_W-1:0]      pbyte,
  input  wire                             en,
  input  wire                             star_en,
  input  gwm_pkg::cell_link_t             link_in,
  output gwm_pkg::cell_link_t             link_out,
  output logic                            res_bit
);

  logic live;
  logic cur;
  logic stay;
  logic hit;
  logic live_next;

  // closed over a star on the left
  assign cur  = live | link_in.fwd;
  assign stay = cur & star_en;
  assign hit  = (pbyte == gwm_pkg::CHAR_ANY) || (pbyte == value_byte);

  assign link_out.fwd = stay;
  assign link_out.adv = cur & en & ~star_en & hit;

  assign live_next = stay | link_in.adv;
  assign res_bit   = ctl.empty ? cur : live_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= START;
    end else if (ctl.step) begin
      live <= ctl.restart ? START : live_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gwm_resolve.sv -----
// Closes a finished position vector over stars and picks the end position.
`default_nettype none

module gwm_resolve #(
  parameter int NPOS = 33
) (
  input  wire  [NPOS-1:0] vec,
  input  wire  [NPOS-1:0] star_en,
  input  wire  [NPOS-1:0] at_end,
  output logic            matched
);

  logic [NPOS-1:0] closed;

  assign closed[0] = vec[0];

  genvar i;
  generate
    for (i = 1; i < NPOS; i++) begin : g_close
      assign closed[i] = vec[i] | (closed[i-1] & star_en[i-1]);
    end
  endgenerate

  assign matched = |(closed & at_end);

endmodule

`default_nettype wire

// ----- hdl/glob_wildcard_matcher_unit.sv -----
// Top level of the streamed glob matcher: config registers, cell row, result stages.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------
//  in      | in  | in_valid / in_stall   | value_byte, last_byte, empty_string
//  out     | out | out_valid / out_stall | matched
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte beat per cycle while in_stall is low: every cell updates its live bit in parallel.
// An ending beat's vector is registered in the vector stage, then closed over stars and
// resolved into the output register, which holds the flag.
// Reset (rst, synchronous) leaves only position 0 live, both stages empty, pattern zero.
// in_stall rises only while the vector stage holds a result that the output
// register cannot take (output full and stalled).
`default_nettype none

module glob_wildcard_matcher_unit #(
  parameter int PATTERN_MAX = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // input byte channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [7:0]                          value_byte,
  input  wire                                 last_byte,
  input  wire                                 empty_string,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic                                matched,
  // configuration write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [gwm_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire  [gwm_pkg::DATA_W-1:0]          cfg_data
);

  localparam int NPOS = PATTERN_MAX + 1;           // positions 0..PATTERN_MAX
  localparam int LW   = $clog2(PATTERN_MAX + 1);   // holds any clamped length
  localparam int CW   = (LW > gwm_pkg::LEN_W) ? LW : gwm_pkg::LEN_W;

  // ---------------------------------------------------------------------------
  // Configuration registers; always ready
  // ---------------------------------------------------------------------------
  logic [gwm_pkg::LEN_W-1:0]  pattern_length;
  logic [gwm_pkg::DATA_W-1:0] pattern_regs [gwm_pkg::PAT_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      for (int k = 0; k < gwm_pkg::PAT_REGS; k++) begin
        pattern_regs[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gwm_pkg::REG_PATTERN_LENGTH:  pattern_length  <= cfg_data[gwm_pkg::LEN_W-1:0];
        gwm_pkg::REG_PATTERN_BYTES_0: pattern_regs[0] <= cfg_data;
        gwm_pkg::REG_PATTERN_BYTES_1: pattern_regs[1] <= cfg_data;
        gwm_pkg::REG_PATTERN_BYTES_2: pattern_regs[2] <= cfg_data;
        gwm_pkg::REG_PATTERN_BYTES_3: pattern_regs[3] <= cfg_data;
        default: ;  // unmapped index: beat dropped
      endcase
    end
  end

  // Length beyond the cell row is taken as the full row
  logic [CW-1:0] len_wide;
  logic [LW-1:0] len_eff;

  assign len_wide = CW'(pattern_length);
  assign len_eff  = (len_wide > CW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(len_wide);

  // ---------------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------------
  logic            in_take;
  logic            ends;
  logic            o_free;
  logic            a_free;
  logic            av;           // vector stage occupied
  logic [NPOS-1:0] a_vec;        // finished position vector
  logic [NPOS-1:0] res_vec;      // per-cell end vector of the current beat
  logic            res_match;

  assign o_free   = ~out_valid | ~out_stall;
  assign a_free   = ~av | o_free;
  assign in_stall = ~a_free;
  assign in_take  = in_valid & ~in_stall;
  assign ends     = last_byte | empty_string;

  gwm_pkg::cell_ctl_t ctl;

  assign ctl.step    = in_take;
  assign ctl.restart = ends;
  assign ctl.empty   = empty_string;

  // ---------------------------------------------------------------------------
  // Per-position pattern decode and the cell row
  // ---------------------------------------------------------------------------
  logic [gwm_pkg::BYTE_W-1:0] pbyte [NPOS];
  logic [NPOS-1:0]            en;       // position lies inside the pattern
  logic [NPOS-1:0]            at_end;   // position equals the pattern length
  logic [NPOS-1:0]            star_en;  // in-pattern star
  gwm_pkg::cell_link_t        link [NPOS+1];

  assign link[0] = '0;

  genvar i;
  generate
    for (i = 0; i < NPOS; i++) begin : g_pos
      if (i < gwm_pkg::REG_BYTES) begin : g_reg
        assign pbyte[i] = pattern_regs[i >> 3][8*(i & 7) +: 8];
      end else begin : g_zero
        assign pbyte[i] = '0;
      end

      assign en[i]      = LW'(i) < len_eff;
      assign at_end[i]  = LW'(i) == len_eff;
      assign star_en[i] = en[i] & (pbyte[i] == gwm_pkg::CHAR_RUN);

      gwm_cell #(
        .START ((i == 0) ? 1'b1 : 1'b0)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .value_byte (value_byte),
        .pbyte      (pbyte[i]),
        .en         (en[i]),
        .star_en    (star_en[i]),
        .link_in    (link[i]),
        .link_out   (link[i+1]),
        .res_bit    (res_vec[i])
      );
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Vector stage: holds an ending beat's positions
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else if (a_free) begin
      av <= in_take & ends;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_take && ends) begin
      a_vec <= res_vec;
    end
  end

  // Closure over trailing stars and pick of the end position
  gwm_resolve #(
    .NPOS (NPOS)
  ) u_resolve (
    .vec     (a_vec),
    .star_en (star_en),
    .at_end  (at_end),
    .matched (res_match)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= av;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && av) begin
      matched <= res_match;
    end
  end

`ifndef ASSERT_OFF
  // stall only comes from a blocked vector stage
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> av && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // an accepted ending beat always lands in the vector stage
  a_end_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (last_byte || empty_string) |=> av)
    else $error("ending beat lost");

  // a blocked vector stage keeps its contents
  a_vec_hold: assert property (@(posedge clk) disable iff (rst)
    av && !o_free |=> av && $stable(a_vec))
    else $error("vector stage changed while blocked");

  // the vector stage empties into the output register
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    av && o_free |=> out_valid)
    else $error("result not moved to output");
`endif

endmodule

`default_nettype wire
